// ===== sv/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  localparam logic [7:0] FinMask    = 8'h80;
  localparam logic [7:0] OpcodeMask = 8'h0F;
  localparam logic [7:0] LenMask    = 8'h7F;
  localparam logic [6:0] LenCode16  = 7'd126;
  localparam logic [6:0] LenCode64  = 7'd127;

  // Extended length and key byte counts, minus one.
  localparam logic [2:0] Ext16Count = 3'd1;
  localparam logic [2:0] Ext64Count = 3'd7;
  localparam logic [2:0] KeyCount   = 3'd3;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        frame_fin;
    logic [3:0]  frame_opcode;
    logic [63:0] frame_length;
    logic        no_payload;
    logic        last_of_frame;
  } result_t;

endpackage

// ===== sv/wsd_if.sv =====
// ----------------------------------------------------------------------------
// wsd_rx_if / wsd_res_if
// Valid/ready channels for stream bytes and for deframed result items.
// ----------------------------------------------------------------------------
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        frame_fin;
  logic [3:0]  frame_opcode;
  logic [63:0] frame_length;
  logic        no_payload;
  logic        last_of_frame;

  modport source(output valid, output payload_byte, output frame_fin, output frame_opcode,
                 output frame_length, output no_payload, output last_of_frame, input ready);
  modport sink(input valid, input payload_byte, input frame_fin, input frame_opcode,
               input frame_length, input no_payload, input last_of_frame, output ready);
endinterface

// ===== sv/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: header decode and payload unmasking.
// ----------------------------------------------------------------------------
// The deframer takes one stream byte per clock and, while the consumer keeps
// up, sustains that rate indefinitely. Each byte passes an input register,
// then the header state machine and unmasking logic, then a result register,
// from which each result is offered to the consumer. Header bytes
// produce nothing, except that the byte completing the header of a zero-length
// frame produces one result flagged no_payload. The input side stalls only
// while the result register holds an item the consumer has not taken.
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsd_rx_if.sink     rx_i,
  wsd_res_if.source  res_o
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_free;
  logic             fire;
  logic             res_valid;
  wsd_pkg::result_t result;

  assign fire = in_valid && out_free;

  wsd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (fire),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  wsd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .result_i (result),
    .free_o   (out_free),
    .res_o    (res_o)
  );

endmodule

// ===== sv/wsd_in_reg.sv =====
// ----------------------------------------------------------------------------
// wsd_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsd_rx_if.sink     rx_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The register refills in the same cycle that its content moves on.
  assign rx_i.ready = !valid_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== sv/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine and payload unmasking, one byte per transfer.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output wsd_pkg::result_t result_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] length_q, length_d;
  logic [2:0]  count_q, count_d;
  logic [31:0] key_q, key_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  key_idx_q, key_idx_d;

  logic [6:0]  code;
  logic [63:0] remain_dec;
  logic [7:0]  key_byte;
  logic        hdr_done;   // header just completed on this byte
  logic        len_done;   // length just completed on this byte

  assign code       = byte_i[6:0] & wsd_pkg::LenMask[6:0];
  assign remain_dec = remain_q - 64'd1;

  always_comb begin
    unique case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    if (!masked_q) begin
      key_byte = 8'h00;
    end
  end

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    masked_d  = masked_q;
    length_d  = length_q;
    count_d   = count_q;
    key_d     = key_q;
    remain_d  = remain_q;
    key_idx_d = key_idx_q;
    len_done  = 1'b0;
    hdr_done  = 1'b0;

    unique case (phase_q)
      wsd_pkg::PH_HDR1: begin
        masked_d = byte_i[7];
        if (code == wsd_pkg::LenCode16 || code == wsd_pkg::LenCode64) begin
          length_d = 64'd0;
          count_d  = (code == wsd_pkg::LenCode16) ? wsd_pkg::Ext16Count
                                                  : wsd_pkg::Ext64Count;
          phase_d  = wsd_pkg::PH_EXT;
        end else begin
          length_d = {57'd0, code};
          len_done = 1'b1;
        end
      end
      wsd_pkg::PH_EXT: begin
        length_d = {length_q[55:0], byte_i};
        if (count_q == 3'd0) begin
          len_done = 1'b1;
        end else begin
          count_d = count_q - 3'd1;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_d = {key_q[23:0], byte_i};
        if (count_q == 3'd0) begin
          hdr_done = 1'b1;
        end else begin
          count_d = count_q - 3'd1;
        end
      end
      wsd_pkg::PH_DATA: begin
        key_idx_d = key_idx_q + 2'd1;
        remain_d  = remain_dec;
        if (remain_dec == 64'd0) begin
          phase_d = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        fin_d    = byte_i[7];
        opcode_d = byte_i[3:0] & wsd_pkg::OpcodeMask[3:0];
        phase_d  = wsd_pkg::PH_HDR1;
      end
    endcase

    // Without a mask the header ends with the length.
    if (len_done) begin
      if (masked_d) begin
        count_d = wsd_pkg::KeyCount;
        phase_d = wsd_pkg::PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      if (length_d == 64'd0) begin
        phase_d = wsd_pkg::PH_HDR0;
      end else begin
        remain_d  = length_d;
        key_idx_d = 2'd0;
        phase_d   = wsd_pkg::PH_DATA;
      end
    end
  end

  // Outputs: a payload byte, or the single marker of an empty frame.
  always_comb begin
    result_o.payload_byte  = 8'h00;
    result_o.frame_fin     = fin_q;
    result_o.frame_opcode  = opcode_q;
    result_o.frame_length  = length_d;
    result_o.no_payload    = 1'b0;
    result_o.last_of_frame = 1'b0;
    res_valid_o            = 1'b0;
    if (phase_q == wsd_pkg::PH_DATA) begin
      result_o.payload_byte  = byte_i ^ key_byte;
      result_o.last_of_frame = (remain_dec == 64'd0);
      res_valid_o            = fire_i;
    end else if (hdr_done && length_d == 64'd0) begin
      result_o.no_payload    = 1'b1;
      result_o.last_of_frame = 1'b1;
      res_valid_o            = fire_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsd_pkg::PH_HDR0;
      fin_q     <= 1'b0;
      opcode_q  <= 4'd0;
      masked_q  <= 1'b0;
      length_q  <= 64'd0;
      count_q   <= 3'd0;
      key_q     <= 32'd0;
      remain_q  <= 64'd0;
      key_idx_q <= 2'd0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      opcode_q  <= opcode_d;
      masked_q  <= masked_d;
      length_q  <= length_d;
      count_q   <= count_d;
      key_q     <= key_d;
      remain_q  <= remain_d;
      key_idx_q <= key_idx_d;
    end
  end

endmodule

// ===== sv/wsd_out_reg.sv =====
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register: holds one deframed item until the consumer takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wsd_pkg::result_t result_i,
  output logic             free_o,
  wsd_res_if.source        res_o
);

  logic             valid_q, valid_d;
  wsd_pkg::result_t data_q;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.payload_byte  = data_q.payload_byte;
  assign res_o.frame_fin     = data_q.frame_fin;
  assign res_o.frame_opcode  = data_q.frame_opcode;
  assign res_o.frame_length  = data_q.frame_length;
  assign res_o.no_payload    = data_q.no_payload;
  assign res_o.last_of_frame = data_q.last_of_frame;

endmodule

// ===== test/websocket_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Drives framed WebSocket byte streams into the deframer and checks every
// result item against an in-bench frame parser. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

  typedef logic [7:0] stream_q_t[$];

  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned RandomBytes = 1300;

  logic clk_i;
  logic rst_ni;

  wsd_rx_if  rx_ch ();
  wsd_res_if res_ch ();

  websocket_frame_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  // Parser state mirrored from the stream bytes that have been transferred.
  wsd_pkg::phase_e hdr_phase  = wsd_pkg::PH_HDR0;
  logic            cur_fin    = 1'b0;
  logic [3:0]      cur_opcode = 4'h0;
  logic            cur_masked = 1'b0;
  logic [63:0]     cur_length = '0;
  logic [2:0]      hdr_left   = '0;
  logic [31:0]     mask_key   = '0;
  logic [63:0]     bytes_left = '0;
  logic [1:0]      key_pos    = '0;

  wsd_pkg::result_t frame_items_q[$];

  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned empty_checked = 0;
  bit          rx_gaps_on    = 1'b1;
  bit          res_stalls_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout after %0d cycles, %0d results still expected", $time,
             cycle_count, frame_items_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short idles, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit header_complete(output wsd_pkg::result_t r);
    if (cur_length == 64'd0) begin
      r.payload_byte  = 8'h00;
      r.frame_fin     = cur_fin;
      r.frame_opcode  = cur_opcode;
      r.frame_length  = cur_length;
      r.no_payload    = 1'b1;
      r.last_of_frame = 1'b1;
      hdr_phase = wsd_pkg::PH_HDR0;
      return 1'b1;
    end
    bytes_left = cur_length;
    key_pos = 2'd0;
    hdr_phase = wsd_pkg::PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit length_known(output wsd_pkg::result_t r);
    r = '0;
    if (cur_masked) begin
      hdr_left = wsd_pkg::KeyCount;
      hdr_phase = wsd_pkg::PH_KEY;
      return 1'b0;
    end
    return header_complete(r);
  endfunction

  // Advances the parser by one stream byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output wsd_pkg::result_t r);
    logic [6:0] code;
    logic [7:0] key_b;
    r = '0;
    case (hdr_phase)
      wsd_pkg::PH_HDR1: begin
        code = 7'(b & wsd_pkg::LenMask);
        cur_masked = (b & wsd_pkg::FinMask) != 8'h00;
        if (code == wsd_pkg::LenCode16 || code == wsd_pkg::LenCode64) begin
          cur_length = '0;
          hdr_left = (code == wsd_pkg::LenCode16) ? wsd_pkg::Ext16Count
                                                  : wsd_pkg::Ext64Count;
          hdr_phase = wsd_pkg::PH_EXT;
          return 1'b0;
        end
        cur_length = 64'(code);
        return length_known(r);
      end
      wsd_pkg::PH_EXT: begin
        cur_length = {cur_length[55:0], b};
        if (hdr_left == 3'd0) return length_known(r);
        hdr_left = hdr_left - 3'd1;
        return 1'b0;
      end
      wsd_pkg::PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (hdr_left == 3'd0) return header_complete(r);
        hdr_left = hdr_left - 3'd1;
        return 1'b0;
      end
      wsd_pkg::PH_DATA: begin
        // Key byte 0 sits in the top byte of the key register.
        key_b = cur_masked ? 8'(mask_key >> (8 * (3 - int'(key_pos)))) : 8'h00;
        key_pos = key_pos + 2'd1;
        bytes_left = bytes_left - 64'd1;
        r.payload_byte  = b ^ key_b;
        r.frame_fin     = cur_fin;
        r.frame_opcode  = cur_opcode;
        r.frame_length  = cur_length;
        r.no_payload    = 1'b0;
        r.last_of_frame = (bytes_left == 64'd0);
        if (r.last_of_frame) hdr_phase = wsd_pkg::PH_HDR0;
        return 1'b1;
      end
      default: begin
        cur_fin = (b & wsd_pkg::FinMask) != 8'h00;
        cur_opcode = 4'(b & wsd_pkg::OpcodeMask);
        hdr_phase = wsd_pkg::PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  // Called and left at a falling edge; valid stays high into the next call.
  task automatic send_byte(input logic [7:0] b);
    wsd_pkg::result_t r;
    int unsigned gap;
    gap = rx_gaps_on ? idle_length() : 0;
    if (gap != 0) begin
      rx_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_ch.valid = 1'b1;
    rx_ch.rx_byte = b;
    do @(posedge clk_i); while (rx_ch.ready !== 1'b1);
    if (deframe_byte(b, r)) frame_items_q.insert(frame_items_q.size(), r);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic void build_header(input logic [7:0] b0, input bit masked,
                                       input logic [63:0] len, input len_form_e form,
                                       input logic [31:0] key, output stream_q_t q);
    logic [6:0] code;
    int n_ext;
    q = {};
    q.insert(q.size(), b0);
    case (form)
      LEN_EXT16: code = wsd_pkg::LenCode16;
      LEN_EXT64: code = wsd_pkg::LenCode64;
      default:   code = len[6:0];
    endcase
    q.insert(q.size(), {masked, code});
    n_ext = (form == LEN_EXT16) ? 2 : (form == LEN_EXT64) ? 8 : 0;
    for (int i = n_ext - 1; i >= 0; i--) q.insert(q.size(), len[8*i +: 8]);
    if (masked) for (int i = 3; i >= 0; i--) q.insert(q.size(), key[8*i +: 8]);
  endfunction

  task automatic send_frame(input logic [7:0] b0, input bit masked, input logic [63:0] len,
                            input len_form_e form, input logic [31:0] key,
                            input int unsigned n_payload);
    stream_q_t q;
    build_header(b0, masked, len, form, key, q);
    repeat (n_payload) q.insert(q.size(), 8'($urandom));
    foreach (q[i]) send_byte(q[i]);
    frames_sent++;
  endtask

  // Random bytes, then more until the parser is back at a frame start.
  task automatic send_noise(input int unsigned n);
    logic [7:0] b;
    for (int unsigned i = 0; i < n || hdr_phase != wsd_pkg::PH_HDR0; i++) begin
      b = 8'($urandom);
      // Zero the upper extended-length bytes so the stream returns to a header soon.
      if (hdr_phase == wsd_pkg::PH_EXT && hdr_left != 3'd0) b = 8'h00;
      send_byte(b);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch on result %0d: expected 0x%0h, actual 0x%0h", $time,
               name, results_seen, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    wsd_pkg::result_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (frame_items_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte 0x%0h last %0b",
                 $time, res_ch.payload_byte, res_ch.last_of_frame);
        fail_count++;
      end else begin
        want = frame_items_q.pop_front();
        compare_field("payload_byte", 64'(want.payload_byte), 64'(res_ch.payload_byte));
        compare_field("frame_fin", 64'(want.frame_fin), 64'(res_ch.frame_fin));
        compare_field("frame_opcode", 64'(want.frame_opcode), 64'(res_ch.frame_opcode));
        compare_field("frame_length", want.frame_length, res_ch.frame_length);
        compare_field("no_payload", 64'(want.no_payload), 64'(res_ch.no_payload));
        compare_field("last_of_frame", 64'(want.last_of_frame),
                      64'(res_ch.last_of_frame));
        if (want.no_payload) empty_checked++;
      end
      results_seen++;
    end
  end

  initial begin : result_stalls
    int unsigned hold;
    hold = 0;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold != 0) hold--;
      else if (res_stalls_on) hold = idle_length();
      res_ch.ready = (hold == 0);
    end
  end

  // Zero-length frames: short form, and masked with a 64-bit length field.
  task automatic test_empty_frames();
    send_frame(8'hFF, 1'b0, 64'd0, LEN_SHORT, 32'h0, 0);
    send_frame(8'h70, 1'b1, 64'd0, LEN_EXT64, 32'hFFFF_FFFF, 0);
  endtask

  // Five masked bytes so the key position wraps around.
  task automatic test_masked_payload();
    send_frame(8'h82, 1'b1, 64'd5, LEN_SHORT, 32'hDEAD_BEEF, 5);
  endtask

  // Non-minimal 16-bit length, unmasked right after a masked frame.
  task automatic test_extended_lengths();
    send_frame(8'h01, 1'b0, 64'd1, LEN_EXT16, 32'h0, 1);
  endtask

  task automatic test_random_stream();
    stream_q_t q;
    int unsigned target, sel, len;
    len_form_e form;
    target = bytes_sent + RandomBytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        rx_gaps_on = 1'b0;
        res_stalls_on = 1'b0;
      end else begin
        rx_gaps_on = $urandom_range(0, 3) != 0;
        res_stalls_on = $urandom_range(0, 3) != 0;
      end
      sel = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      if (len < 18) len = 0;
      else if (len < 82) len = $urandom_range(1, 12);
      else if (len < 96) len = $urandom_range(13, 125);
      else len = $urandom_range(126, 300);
      if (len > 125) form = ($urandom_range(0, 1) != 0) ? LEN_EXT16 : LEN_EXT64;
      else if ($urandom_range(0, 99) < 60) form = LEN_SHORT;
      else form = ($urandom_range(0, 2) != 0) ? LEN_EXT16 : LEN_EXT64;
      if (sel < 80) begin
        send_frame(8'($urandom), 1'($urandom), 64'(len), form, $urandom, len);
      end else if (sel < 90) begin
        send_noise($urandom_range(1, 12));
      end else begin
        // Cut a header short and let random bytes run into it.
        build_header(8'($urandom), 1'($urandom), 64'(len), form, $urandom, q);
        for (int i = 0; i < $urandom_range(1, q.size()); i++) send_byte(q[i]);
        send_noise($urandom_range(0, 4));
      end
    end
    rx_gaps_on = 1'b1;
    res_stalls_on = 1'b1;
  endtask

  // All-ones length: never completes, so this frame closes the run.
  task automatic test_length_top_bit();
    send_frame(8'h82, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, LEN_EXT64, 32'hA5C3_0FF0, 24);
  endtask

  initial begin
    rst_ni = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_frames();
    test_masked_payload();
    test_extended_lengths();
    test_random_stream();
    test_length_top_bit();

    rx_ch.valid = 1'b0;
    while (frame_items_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Summary: %0d stream bytes in %0d whole frames plus noise and cut headers,",
             bytes_sent, frames_sent);
    $display("Summary: %0d results checked, %0d of them empty-frame markers, %0d errors.",
             results_seen, empty_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
